// File: rtl/cau_pkg.sv
// ============================================================================
// cau_pkg: shared types and constants of the complex arithmetic unit
// Word formats, command codes, internal widths, the arctangent table and
// the saturating clamp used by the front stages and the output stage.
// ============================================================================
package cau_pkg;

    // Data format: signed Q3.12
    localparam int DATA_W       = 16;
    localparam int FRAC_W       = 12;

    // Internal widths
    localparam int PROD_W       = 2 * DATA_W;             // one product or a sum of squares
    localparam int SUM_W        = PROD_W + 1;             // signed sum of two products
    localparam int REM_W        = PROD_W + FRAC_W;        // scaled dividend
    localparam int DIV_STEPS    = DATA_W + 1;             // quotient bits kept
    localparam int Q_W          = DIV_STEPS;
    localparam int CMP_W        = PROD_W + DIV_STEPS;     // shifted divisor
    localparam int OVF_SH       = DIV_STEPS - FRAC_W;     // quotient overflow test shift
    localparam int SQRT_STEPS   = DATA_W;                 // root bits
    localparam int CORDIC_STEPS = 16;
    localparam int CHAIN_LEN    = DIV_STEPS;              // longest of the three iterations
    localparam int CX_W         = DATA_W + 4;             // CORDIC x/y with gain headroom
    localparam int CZ_W         = 36;                     // angle, 32 fraction bits
    localparam int ANG_SH       = 32 - FRAC_W;            // angle fraction bits dropped
    localparam int CLAMP_W      = PROD_W;

    // Command codes
    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_MAG = 3'd4,
        CMD_ANG = 3'd5
    } t_cmd;

    // pi/2 with 32 fraction bits
    localparam logic signed [CZ_W-1:0] ANGLE_QUARTER = 36'sd6746518852;

    // atan(2^-i), 32 fraction bits
    localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635,
        32'd268086748,  32'd134174063,  32'd67103403,   32'd33553749,
        32'd16777131,   32'd8388597,    32'd4194303,    32'd2097152,
        32'd1048576,    32'd524288,     32'd262144,     32'd131072
    };

    // Input word
    typedef struct packed {
        logic [2:0]               command;
        logic signed [DATA_W-1:0] a_real;
        logic signed [DATA_W-1:0] a_imag;
        logic signed [DATA_W-1:0] b_real;
        logic signed [DATA_W-1:0] b_imag;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic signed [DATA_W-1:0] result_real;
        logic signed [DATA_W-1:0] result_imag;
        logic                     divide_by_zero;
        logic                     saturated;
    } t_out_word;

    // Word handed from cell to cell
    typedef struct packed {
        logic [2:0]               cmd;
        // finished add / subtract / multiply result
        logic [DATA_W-1:0]        fin_re;
        logic [DATA_W-1:0]        fin_im;
        logic                     fin_sat;
        // divide
        logic                     dz;
        logic                     neg_re;
        logic                     neg_im;
        logic                     ovf_re;
        logic                     ovf_im;
        logic [PROD_W-1:0]        d;
        logic [REM_W-1:0]         rem_re;
        logic [REM_W-1:0]         rem_im;
        logic [Q_W-1:0]           q_re;
        logic [Q_W-1:0]           q_im;
        // magnitude
        logic [PROD_W-1:0]        sq_s;
        logic [PROD_W-1:0]        sq_res;
        // angle
        logic signed [CX_W-1:0]   cx;
        logic signed [CX_W-1:0]   cy;
        logic signed [CZ_W-1:0]   cz;
        logic                     czero;
    } t_cell_word;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              sat;
    } t_clamp;

    // Sign and magnitude to the signed data range, with a saturation flag
    function automatic t_clamp clamp_smag(input logic neg, input logic [CLAMP_W-1:0] mag);
        logic [CLAMP_W-1:0] lim;
        logic [CLAMP_W-1:0] m;
        t_clamp             r;
        lim = {{(CLAMP_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}} + CLAMP_W'(neg);
        r.sat = (mag > lim);
        m = r.sat ? lim : mag;
        r.value = neg ? (DATA_W'(0) - m[DATA_W-1:0]) : m[DATA_W-1:0];
        return r;
    endfunction

endpackage

// File: rtl/complex_arithmetic_unit.sv
// ============================================================================
// complex_arithmetic_unit: pipelined complex ALU in signed Q3.12
// Add, subtract, multiply, divide, magnitude and angle of complex words.
// ============================================================================
// Usage:
//   Input channel i_valid / o_stall carries a t_in_word: a command and the
//   complex operands A and B. A word is taken on a clock edge with i_valid
//   high and o_stall low. Output channel o_valid / i_stall carries a
//   t_out_word: the complex result plus divide-by-zero and saturation flags.
//   From acceptance to o_valid a word passes one product stage, two operand
//   stages, a chain of 17 cells and the output register. The chain length
//   is set by the divider, which produces one quotient bit per cell; square
//   root and CORDIC use 16 of the cells. Throughput is one word per cycle
//   for every command mix while the receiver does not stall.
//   When the receiver stalls, the output register holds its word and stages
//   behind it keep filling empty slots, so input is still taken until the
//   pipeline is full; after that o_stall follows the output stall.
//   Reset (synchronous, active low) empties every stage; no result is
//   presented until new words are taken.
// ============================================================================
module complex_arithmetic_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  cau_pkg::t_in_word  i_word,
    output logic               o_valid,
    input  logic               i_stall,
    output cau_pkg::t_out_word o_word
);
    import cau_pkg::*;

    logic       front_ready;
    logic       chain_valid [CHAIN_LEN+1];
    logic       chain_ready [CHAIN_LEN+1];
    t_cell_word chain_word  [CHAIN_LEN+1];

    assign o_stall = !front_ready;

    // Operand stages
    cau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_word  (i_word),
        .o_ready (front_ready),
        .o_valid (chain_valid[0]),
        .o_word  (chain_word[0]),
        .i_ready (chain_ready[0])
    );

    // Cell chain
    for (genvar k = 0; k < CHAIN_LEN; k++) begin : g_cell
        cau_cell #(
            .STEP (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[k]),
            .i_word  (chain_word[k]),
            .o_ready (chain_ready[k]),
            .o_valid (chain_valid[k+1]),
            .o_word  (chain_word[k+1]),
            .i_ready (chain_ready[k+1])
        );
    end

    // Rounding and output register
    cau_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (chain_valid[CHAIN_LEN]),
        .i_word  (chain_word[CHAIN_LEN]),
        .o_ready (chain_ready[CHAIN_LEN]),
        .o_valid (o_valid),
        .o_word  (o_word),
        .i_stall (i_stall)
    );

endmodule

// File: rtl/cau_front.sv
// ============================================================================
// cau_front: operand stages ahead of the cell chain
// Three registered stages: the six products, the sums and CORDIC
// pre-rotation, then clamping of add/sub/mul (rounding mul) and
// set-up of divide, square root and CORDIC words for the chain.
// ============================================================================
module cau_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  cau_pkg::t_in_word   i_word,
    output logic                o_ready,
    output logic                o_valid,
    output cau_pkg::t_cell_word o_word,
    input  logic                i_ready
);
    import cau_pkg::*;

    typedef struct packed {
        logic [2:0]               cmd;
        logic signed [DATA_W-1:0] ar;
        logic signed [DATA_W-1:0] ai;
        logic signed [DATA_W-1:0] br;
        logic signed [DATA_W-1:0] bi;
        logic signed [PROD_W-1:0] p1;   // ar*br
        logic signed [PROD_W-1:0] p2;   // ai*bi
        logic signed [PROD_W-1:0] p3;   // ar*bi
        logic signed [PROD_W-1:0] p4;   // ai*br
        logic [PROD_W-1:0]        sq_a;
        logic [PROD_W-1:0]        sq_b;
    } t_prod_word;

    typedef struct packed {
        logic [2:0]              cmd;
        logic signed [SUM_W-1:0] sum_re;
        logic signed [SUM_W-1:0] sum_im;
        logic [PROD_W-1:0]       dsum;
        logic signed [CX_W-1:0]  cx;
        logic signed [CX_W-1:0]  cy;
        logic signed [CZ_W-1:0]  cz;
        logic                    czero;
    } t_sum_word;

    logic                     r1_valid, r2_valid, r3_valid;
    logic                     rdy1, rdy2, rdy3;
    t_prod_word               r1_word, n1_word;
    t_sum_word                r2_word, n2_word;
    t_cell_word               r3_word, n3_word;
    logic signed [DATA_W-1:0] sq_op_a, sq_op_b;
    logic signed [PROD_W-1:0] sq_pa, sq_pb;
    logic [PROD_W-1:0]        mag_re, mag_im;
    logic [SUM_W-1:0]         rsum_re, rsum_im;
    t_clamp                   cl_re, cl_im;

    // Stage advance: a stage moves when it is empty or its successor moves
    assign rdy3    = !r3_valid || i_ready;
    assign rdy2    = !r2_valid || rdy3;
    assign rdy1    = !r1_valid || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r3_valid;
    assign o_word  = r3_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            if (rdy1) r1_valid <= i_valid;
            if (rdy2) r2_valid <= r1_valid;
            if (rdy3) r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) r1_word <= n1_word;
        if (rdy2) r2_word <= n2_word;
        if (rdy3) r3_word <= n3_word;
    end

    // Stage 1: products; the squares serve |A|^2 for magnitude, |B|^2 otherwise
    always_comb begin
        sq_op_a = (i_word.command == CMD_MAG) ? i_word.a_real : i_word.b_real;
        sq_op_b = (i_word.command == CMD_MAG) ? i_word.a_imag : i_word.b_imag;
        sq_pa   = sq_op_a * sq_op_a;
        sq_pb   = sq_op_b * sq_op_b;
        n1_word.cmd  = i_word.command;
        n1_word.ar   = i_word.a_real;
        n1_word.ai   = i_word.a_imag;
        n1_word.br   = i_word.b_real;
        n1_word.bi   = i_word.b_imag;
        n1_word.p1   = i_word.a_real * i_word.b_real;
        n1_word.p2   = i_word.a_imag * i_word.b_imag;
        n1_word.p3   = i_word.a_real * i_word.b_imag;
        n1_word.p4   = i_word.a_imag * i_word.b_real;
        n1_word.sq_a = sq_pa;
        n1_word.sq_b = sq_pb;
    end

    // Stage 2: sums and CORDIC pre-rotation into the right half plane
    always_comb begin
        n2_word.cmd  = r1_word.cmd;
        n2_word.dsum = r1_word.sq_a + r1_word.sq_b;
        unique case (r1_word.cmd)
            CMD_ADD: begin
                n2_word.sum_re = SUM_W'(r1_word.ar) + SUM_W'(r1_word.br);
                n2_word.sum_im = SUM_W'(r1_word.ai) + SUM_W'(r1_word.bi);
            end
            CMD_SUB: begin
                n2_word.sum_re = SUM_W'(r1_word.ar) - SUM_W'(r1_word.br);
                n2_word.sum_im = SUM_W'(r1_word.ai) - SUM_W'(r1_word.bi);
            end
            CMD_MUL: begin
                n2_word.sum_re = SUM_W'(r1_word.p1) - SUM_W'(r1_word.p2);
                n2_word.sum_im = SUM_W'(r1_word.p3) + SUM_W'(r1_word.p4);
            end
            CMD_DIV: begin
                n2_word.sum_re = SUM_W'(r1_word.p1) + SUM_W'(r1_word.p2);
                n2_word.sum_im = SUM_W'(r1_word.p4) - SUM_W'(r1_word.p3);
            end
            default: begin
                n2_word.sum_re = '0;
                n2_word.sum_im = '0;
            end
        endcase
        n2_word.czero = (r1_word.ar == '0) && (r1_word.ai == '0);
        if (r1_word.ar[DATA_W-1] && !r1_word.ai[DATA_W-1]) begin
            // second quadrant: turn by -90 degrees
            n2_word.cx = CX_W'(r1_word.ai);
            n2_word.cy = CX_W'(0) - CX_W'(r1_word.ar);
            n2_word.cz = ANGLE_QUARTER;
        end else if (r1_word.ar[DATA_W-1]) begin
            // third quadrant: turn by +90 degrees
            n2_word.cx = CX_W'(0) - CX_W'(r1_word.ai);
            n2_word.cy = CX_W'(r1_word.ar);
            n2_word.cz = CZ_W'(0) - ANGLE_QUARTER;
        end else begin
            n2_word.cx = CX_W'(r1_word.ar);
            n2_word.cy = CX_W'(r1_word.ai);
            n2_word.cz = '0;
        end
    end

    // Stage 3: finish add/sub/mul, set up divide, root and angle
    always_comb begin
        mag_re  = r2_word.sum_re[SUM_W-1] ? PROD_W'(-r2_word.sum_re) : PROD_W'(r2_word.sum_re);
        mag_im  = r2_word.sum_im[SUM_W-1] ? PROD_W'(-r2_word.sum_im) : PROD_W'(r2_word.sum_im);
        rsum_re = SUM_W'(mag_re) + (SUM_W'(1) << (FRAC_W - 1));
        rsum_im = SUM_W'(mag_im) + (SUM_W'(1) << (FRAC_W - 1));
        if (r2_word.cmd == CMD_MUL) begin
            cl_re = clamp_smag(r2_word.sum_re[SUM_W-1], CLAMP_W'(rsum_re[SUM_W-1:FRAC_W]));
            cl_im = clamp_smag(r2_word.sum_im[SUM_W-1], CLAMP_W'(rsum_im[SUM_W-1:FRAC_W]));
        end else begin
            cl_re = clamp_smag(r2_word.sum_re[SUM_W-1], mag_re);
            cl_im = clamp_smag(r2_word.sum_im[SUM_W-1], mag_im);
        end

        n3_word.cmd     = r2_word.cmd;
        n3_word.fin_re  = cl_re.value;
        n3_word.fin_im  = cl_im.value;
        n3_word.fin_sat = cl_re.sat || cl_im.sat;

        n3_word.dz      = (r2_word.dsum == '0);
        n3_word.neg_re  = r2_word.sum_re[SUM_W-1];
        n3_word.neg_im  = r2_word.sum_im[SUM_W-1];
        // quotient would need more than DIV_STEPS bits
        n3_word.ovf_re  = (PROD_W+OVF_SH)'(mag_re) >= {r2_word.dsum, OVF_SH'(0)};
        n3_word.ovf_im  = (PROD_W+OVF_SH)'(mag_im) >= {r2_word.dsum, OVF_SH'(0)};
        n3_word.d       = r2_word.dsum;
        n3_word.rem_re  = {mag_re, FRAC_W'(0)};
        n3_word.rem_im  = {mag_im, FRAC_W'(0)};
        n3_word.q_re    = '0;
        n3_word.q_im    = '0;

        n3_word.sq_s    = r2_word.dsum;
        n3_word.sq_res  = '0;

        n3_word.cx      = r2_word.cx;
        n3_word.cy      = r2_word.cy;
        n3_word.cz      = r2_word.cz;
        n3_word.czero   = r2_word.czero;
    end

endmodule

// File: rtl/cau_cell.sv
// ============================================================================
// cau_cell: one step of the iterative chain
// Depending on the command, performs one restoring-divide bit on both
// quotients, one square-root bit or one CORDIC vectoring rotation, or
// passes it on unchanged; then registers the word for the next cell.
// ============================================================================
module cau_cell #(
    parameter int STEP = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  cau_pkg::t_cell_word i_word,
    output logic                o_ready,
    output logic                o_valid,
    output cau_pkg::t_cell_word o_word,
    input  logic                i_ready
);
    import cau_pkg::*;

    localparam int DIV_SH = DIV_STEPS - 1 - STEP;
    localparam bit SQ_ON  = (STEP < SQRT_STEPS);
    localparam int SQ_SH  = SQ_ON ? 2 * (SQRT_STEPS - 1 - STEP) : 0;
    localparam bit CO_ON  = (STEP < CORDIC_STEPS);
    localparam int AT_IDX = CO_ON ? STEP : 0;

    logic                   r_valid;
    t_cell_word             r_word, n_word;
    logic [CMP_W-1:0]       div_sh;
    logic [PROD_W-1:0]      sq_bit;
    logic [PROD_W:0]        trial;
    logic signed [CX_W-1:0] xs, ys;
    logic                   y_pos;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) r_word <= n_word;
    end

    always_comb begin
        div_sh = CMP_W'(i_word.d) << DIV_SH;
        sq_bit = PROD_W'(1) << SQ_SH;
        trial  = (PROD_W+1)'(i_word.sq_res) + (PROD_W+1)'(sq_bit);
        xs     = $signed(i_word.cx) >>> STEP;
        ys     = $signed(i_word.cy) >>> STEP;
        y_pos  = !i_word.cy[CX_W-1] && (i_word.cy != '0);
        n_word = i_word;
        unique case (i_word.cmd)
            // one quotient bit for each part
            CMD_DIV: begin
                if (CMP_W'(i_word.rem_re) >= div_sh) begin
                    n_word.rem_re = i_word.rem_re - REM_W'(div_sh);
                    n_word.q_re   = {i_word.q_re[Q_W-2:0], 1'b1};
                end else begin
                    n_word.q_re   = {i_word.q_re[Q_W-2:0], 1'b0};
                end
                if (CMP_W'(i_word.rem_im) >= div_sh) begin
                    n_word.rem_im = i_word.rem_im - REM_W'(div_sh);
                    n_word.q_im   = {i_word.q_im[Q_W-2:0], 1'b1};
                end else begin
                    n_word.q_im   = {i_word.q_im[Q_W-2:0], 1'b0};
                end
            end
            // one root bit
            CMD_MAG: begin
                if (SQ_ON) begin
                    if ((PROD_W+1)'(i_word.sq_s) >= trial) begin
                        n_word.sq_s   = i_word.sq_s - trial[PROD_W-1:0];
                        n_word.sq_res = (i_word.sq_res >> 1) + sq_bit;
                    end else begin
                        n_word.sq_res = i_word.sq_res >> 1;
                    end
                end
            end
            // one vectoring rotation, driving y toward zero
            CMD_ANG: begin
                if (CO_ON) begin
                    if (y_pos) begin
                        n_word.cx = i_word.cx + ys;
                        n_word.cy = i_word.cy - xs;
                        n_word.cz = i_word.cz + CZ_W'(ATAN_TAB[AT_IDX]);
                    end else begin
                        n_word.cx = i_word.cx - ys;
                        n_word.cy = i_word.cy + xs;
                        n_word.cz = i_word.cz - CZ_W'(ATAN_TAB[AT_IDX]);
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

// File: rtl/cau_back.sv
// ============================================================================
// cau_back: result rounding and output register
// Rounds quotients and the root, scales the angle, clamps, and holds the
// result word until the receiver takes it.
// ============================================================================
module cau_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  cau_pkg::t_cell_word i_word,
    output logic                o_ready,
    output logic                o_valid,
    output cau_pkg::t_out_word  o_word,
    input  logic                i_stall
);
    import cau_pkg::*;

    logic              r_valid;
    t_out_word         r_word, n_word;
    logic              rnd_re, rnd_im, sq_rnd;
    logic [CLAMP_W-1:0] qm_re, qm_im, root;
    logic signed [CZ_W-1:0] zr;
    t_clamp            cl_re, cl_im, cl_mag;

    assign o_ready = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) r_word <= n_word;
    end

    always_comb begin
        // divide: round half away from zero, overflow forces the limit
        rnd_re = {i_word.rem_re[PROD_W-2:0], 1'b0} >= i_word.d;
        rnd_im = {i_word.rem_im[PROD_W-2:0], 1'b0} >= i_word.d;
        qm_re  = i_word.ovf_re ? '1 : CLAMP_W'(i_word.q_re) + CLAMP_W'(rnd_re);
        qm_im  = i_word.ovf_im ? '1 : CLAMP_W'(i_word.q_im) + CLAMP_W'(rnd_im);
        cl_re  = clamp_smag(i_word.neg_re, qm_re);
        cl_im  = clamp_smag(i_word.neg_im, qm_im);
        // root: round to nearest from the remainder
        sq_rnd = i_word.sq_s > i_word.sq_res;
        root   = i_word.sq_res + CLAMP_W'(sq_rnd);
        cl_mag = clamp_smag(1'b0, root);
        // angle: round half up to FRAC_W fraction bits
        zr     = i_word.cz + (CZ_W'(1) << (ANG_SH - 1));

        n_word = '0;
        unique case (i_word.cmd)
            CMD_ADD, CMD_SUB, CMD_MUL: begin
                n_word.result_real = i_word.fin_re;
                n_word.result_imag = i_word.fin_im;
                n_word.saturated   = i_word.fin_sat;
            end
            CMD_DIV: begin
                if (i_word.dz) begin
                    n_word.divide_by_zero = 1'b1;
                end else begin
                    n_word.result_real = cl_re.value;
                    n_word.result_imag = cl_im.value;
                    n_word.saturated   = cl_re.sat || cl_im.sat;
                end
            end
            CMD_MAG: begin
                n_word.result_real = cl_mag.value;
                n_word.saturated   = cl_mag.sat;
            end
            CMD_ANG: begin
                if (!i_word.czero) begin
                    n_word.result_real = zr[CZ_W-1:ANG_SH];
                end
            end
            default: ;
        endcase
    end

endmodule
